/* src/bms_pkg.sv */
// Shared types and codes for the balanced multi-stack unit.
// No dependencies; every other file in src refers to this package by scoped names.
`default_nettype none

package bms_pkg;

  // Operation selector carried on the input tuser bit.
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  // Result status codes carried on the output tuser bits.
  localparam int unsigned STATUS_W = 2;
  localparam logic [STATUS_W-1:0] ST_PUSHED    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PUSH_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_POPPED    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 2'd3;

  // Fixed field widths of the stream payload.
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned INDEX_W = 3;

  // Decision made by the occupancy tracker for one transaction.
  typedef struct packed {
    logic                is_pop;
    logic                ok;
    logic [STATUS_W-1:0] status;
  } bms_dec_t;

  // Enables toward the stack storage.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } bms_mem_ctl_t;

endpackage

`default_nettype wire

/* src/bms_occ.sv */
// Occupancy counters of all stacks, with the shortest/longest stack selection.
// Depends on bms_pkg for the decision struct and status codes.
`default_nettype none

module bms_occ #(
  parameter int unsigned NUM_STACKS  = 5,
  parameter int unsigned STACK_DEPTH = 4,
  parameter int unsigned IDX_W       = 3,
  parameter int unsigned OCC_W       = 3
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             fire,
  input  wire logic             mode,
  output bms_pkg::bms_dec_t     dec,
  output logic [IDX_W-1:0]      sel_idx,
  output logic [OCC_W-1:0]      sel_occ
);

  logic [OCC_W-1:0]      occ_r   [NUM_STACKS];
  logic [OCC_W-1:0]      occ_nxt [NUM_STACKS];
  logic [NUM_STACKS-1:0] win;
  logic                  is_pop;
  logic                  full;
  logic                  empty;

  assign is_pop = (mode == bms_pkg::MODE_POP);

  // Each stack checks itself against all others: it wins when it beats every
  // lower index strictly and every higher index or ties it. Exactly one wins.
  always_comb begin
    for (int i = 0; i < NUM_STACKS; i++) begin
      win[i] = 1'b1;
      for (int j = 0; j < NUM_STACKS; j++) begin
        if (j < i) begin
          if (is_pop) begin
            win[i] = win[i] & (occ_r[i] > occ_r[j]);
          end else begin
            win[i] = win[i] & (occ_r[i] < occ_r[j]);
          end
        end else if (j > i) begin
          if (is_pop) begin
            win[i] = win[i] & (occ_r[i] >= occ_r[j]);
          end else begin
            win[i] = win[i] & (occ_r[i] <= occ_r[j]);
          end
        end
      end
    end
  end

  always_comb begin
    sel_idx = '0;
    sel_occ = '0;
    for (int i = 0; i < NUM_STACKS; i++) begin
      sel_idx = sel_idx | (IDX_W'(i) & {IDX_W{win[i]}});
      sel_occ = sel_occ | (occ_r[i] & {OCC_W{win[i]}});
    end
  end

  assign full  = (sel_occ >= OCC_W'(STACK_DEPTH));
  assign empty = (sel_occ == '0);

  always_comb begin
    dec.is_pop = is_pop;
    dec.ok     = is_pop ? !empty : !full;
    if (is_pop) begin
      dec.status = empty ? bms_pkg::ST_POP_EMPTY : bms_pkg::ST_POPPED;
    end else begin
      dec.status = full ? bms_pkg::ST_PUSH_FULL : bms_pkg::ST_PUSHED;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_STACKS; i++) begin
      occ_nxt[i] = occ_r[i];
      if (fire && dec.ok && (sel_idx == IDX_W'(i))) begin
        occ_nxt[i] = is_pop ? (occ_r[i] - OCC_W'(1)) : (occ_r[i] + OCC_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_STACKS; i++) begin
      if (!rst_n) begin
        occ_r[i] <= '0;
      end else begin
        occ_r[i] <= occ_nxt[i];
      end
    end
  end

endmodule

`default_nettype wire

/* src/bms_store.sv */
// Stack contents: one write port and one registered read port.
// Depends on bms_pkg for the control struct.
`default_nettype none

module bms_store #(
  parameter int unsigned ENTRIES    = 20,
  parameter int unsigned ADDR_W     = 5,
  parameter int unsigned DATA_WIDTH = 16
) (
  input  wire logic                   clk,
  input  wire bms_pkg::bms_mem_ctl_t  ctl,
  input  wire logic [ADDR_W-1:0]      addr,
  input  wire logic [DATA_WIDTH-1:0]  wr_data,
  output logic      [DATA_WIDTH-1:0]  rd_data_r
);

  logic [DATA_WIDTH-1:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= wr_data;
    end
  end

  // Read data holds while the result stage is stalled.
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

endmodule

`default_nettype wire

/* src/balanced_multi_stack_unit.sv */
// Top level of the balanced multi-stack unit: stream ports, input and result stages.
// Depends on bms_pkg, bms_occ and bms_store.
`default_nettype none

// Channel  Direction  Payload
// in_      slave      tuser = mode (0 push, 1 pop); tdata = value
// out_     master     tuser = status; tdata = stack_index, popped_value
//
// One transaction enters per clock while in_tready is high. An accepted transaction
// sits in the input register, where the stack choice, counter update and storage
// access are made; it then lands in the result register, from which its result
// shows on the output. The move into the result register waits while a result is stalled there.
// The rate is one transaction per cycle when the output does not stall, set by the
// single pass through the occupancy selection and the one storage port.
// rst_n is synchronous and active low; it empties every stack and both stages.
// A stalled result holds the result register, which in turn holds the input
// register once both are full; in_tready then drops.
module balanced_multi_stack_unit #(
  parameter int unsigned NUM_STACKS  = 5,
  parameter int unsigned STACK_DEPTH = 4,
  parameter int unsigned DATA_WIDTH  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] value
  input  wire logic        in_tuser,   // [0] mode
  // Result channel.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [23:0] out_tdata,  // [2:0] stack_index, [18:3] popped_value, rest zero
  output logic      [1:0]  out_tuser   // [1:0] status
);

  localparam int unsigned IDX_W   = $clog2(NUM_STACKS);
  localparam int unsigned OCC_W   = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ENTRIES = NUM_STACKS * STACK_DEPTH;
  localparam int unsigned ADDR_W  = $clog2(ENTRIES);
  localparam int unsigned VW      = bms_pkg::VALUE_W;

  // Input stage.
  logic                  a_valid_r;
  logic                  a_mode_r;
  logic [VW-1:0]         a_value_r;
  // Result stage; popped data lives in the storage read register.
  logic                  b_valid_r;
  logic [bms_pkg::STATUS_W-1:0] b_status_r;
  logic [bms_pkg::INDEX_W-1:0]  b_index_r;

  logic                  in_fire;
  logic                  a_fire;
  logic                  b_free;

  bms_pkg::bms_dec_t     dec;
  bms_pkg::bms_mem_ctl_t mem_ctl;
  logic [IDX_W-1:0]      sel_idx;
  logic [OCC_W-1:0]      sel_occ;
  logic [OCC_W-1:0]      level;
  logic [ADDR_W-1:0]     addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [VW-1:0]         popped_value;

  // Handshake: the result register frees when it is empty or being taken; the
  // input register moves forward whenever the result register is free.
  assign b_free    = !b_valid_r || out_tready;
  assign a_fire    = a_valid_r && b_free;
  assign in_tready = !a_valid_r || b_free;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_tready) begin
      a_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_mode_r  <= in_tuser;
      a_value_r <= in_tdata;
    end
  end

  bms_occ #(
    .NUM_STACKS  (NUM_STACKS),
    .STACK_DEPTH (STACK_DEPTH),
    .IDX_W       (IDX_W),
    .OCC_W       (OCC_W)
  ) u_occ (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (a_fire),
    .mode    (a_mode_r),
    .dec     (dec),
    .sel_idx (sel_idx),
    .sel_occ (sel_occ)
  );

  // A push writes the slot just above the top; a pop reads the top slot.
  assign level = dec.is_pop ? (sel_occ - OCC_W'(1)) : sel_occ;
  assign addr  = ADDR_W'(int'(sel_idx) * STACK_DEPTH + int'(level));

  assign mem_ctl.wr_en = a_fire && dec.ok && !dec.is_pop;
  assign mem_ctl.rd_en = a_fire && dec.ok && dec.is_pop;

  // The stored word keeps the low DATA_WIDTH bits of the pushed value, zero-extended when DATA_WIDTH is wider.
  generate
    if (DATA_WIDTH <= VW) begin : g_wr_narrow
      assign wr_data = a_value_r[DATA_WIDTH-1:0];
    end else begin : g_wr_wide
      assign wr_data = {{(DATA_WIDTH - VW){1'b0}}, a_value_r};
    end
  endgenerate

  bms_store #(
    .ENTRIES    (ENTRIES),
    .ADDR_W     (ADDR_W),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store (
    .clk       (clk),
    .ctl       (mem_ctl),
    .addr      (addr),
    .wr_data   (wr_data),
    .rd_data_r (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_free) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire) begin
      b_status_r <= dec.status;
      b_index_r  <= bms_pkg::INDEX_W'(sel_idx);
    end
  end

  // Only a successful pop shows stored data; every other result reads zero.
  generate
    if (DATA_WIDTH >= VW) begin : g_rd_wide
      assign popped_value = (b_status_r == bms_pkg::ST_POPPED) ? rd_data[VW-1:0] : '0;
    end else begin : g_rd_narrow
      assign popped_value = (b_status_r == bms_pkg::ST_POPPED) ?
                            {{(VW - DATA_WIDTH){1'b0}}, rd_data} : '0;
    end
  endgenerate

  assign out_tvalid = b_valid_r;
  assign out_tuser  = b_status_r;
  assign out_tdata  = {5'd0, popped_value, b_index_r};

`ifndef SYNTHESIS
  // A dropped push or an empty pop means every stack tied, so stack 0 is chosen.
  a_tie_index : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == bms_pkg::ST_PUSH_FULL ||
                    out_tuser == bms_pkg::ST_POP_EMPTY)) |-> (out_tdata[2:0] == 3'd0))
    else $error("all-full or all-empty result names a stack other than 0");

  // Only a successful pop may carry data.
  a_zero_data : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != bms_pkg::ST_POPPED) |-> (out_tdata[18:3] == 16'd0))
    else $error("non-pop result carries nonzero data");

  // With no result waiting, the unit must take a new transaction.
  a_ready_free : assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty result stage");

  // A transaction in the input stage reaches the result stage on the next cycle
  // when nothing is waiting there.
  a_advance : assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && !b_valid_r) |=> out_tvalid)
    else $error("transaction lost between the input and result stages");

  // The storage is never written and read in the same cycle.
  a_one_port : assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_ctl.wr_en && mem_ctl.rd_en))
    else $error("storage written and read together");
`endif

endmodule

`default_nettype wire

/* tb/stack_bank_check_pkg.sv */
// Scoreboard for the balanced multi-stack unit: a predictor of the stack bank
// plus the store of expected results. Depends on bms_pkg for widths and codes.
package stack_bank_check_pkg;
  import bms_pkg::*;

  localparam int unsigned BANK_STACKS = 5;
  localparam int unsigned BANK_DEPTH  = 4;
  localparam int unsigned MAX_PRINTED = 40;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  stack_index;
    logic [VALUE_W-1:0]  popped_value;
  } stack_result_t;

  class stack_bank_scoreboard;
    int unsigned         fill_level [BANK_STACKS];
    logic [VALUE_W-1:0]  bank [BANK_STACKS][BANK_DEPTH];
    stack_result_t       expected_q [$];
    int unsigned         errors;

    function new();
      foreach (fill_level[i]) fill_level[i] = 0;
      errors = 0;
    endfunction

    // Applies one accepted transaction to the bank copy and queues its result.
    function void note_request(logic mode, logic [VALUE_W-1:0] value);
      int unsigned   pick;
      stack_result_t res;
      pick = 0;
      res.popped_value = '0;
      if (mode == MODE_PUSH) begin
        for (int i = 1; i < BANK_STACKS; i++)
          if (fill_level[i] < fill_level[pick]) pick = i;
        if (fill_level[pick] >= BANK_DEPTH) begin
          res.status = ST_PUSH_FULL;
        end else begin
          bank[pick][fill_level[pick]] = value;
          fill_level[pick]++;
          res.status = ST_PUSHED;
        end
      end else begin
        for (int i = 1; i < BANK_STACKS; i++)
          if (fill_level[i] > fill_level[pick]) pick = i;
        if (fill_level[pick] == 0) begin
          res.status = ST_POP_EMPTY;
        end else begin
          fill_level[pick]--;
          res.popped_value = bank[pick][fill_level[pick]];
          res.status = ST_POPPED;
        end
      end
      res.stack_index = pick[INDEX_W-1:0];
      expected_q.push_back(res);
    endfunction

    task report_mismatch(string msg);
      if (errors < MAX_PRINTED) $display("ERROR at %0t: %s", $time, msg);
      errors++;
    endtask

    // Compares one accepted result with the oldest expectation.
    task check_result(logic [23:0] tdata, logic [STATUS_W-1:0] tuser);
      stack_result_t want;
      logic [INDEX_W-1:0] got_index;
      logic [VALUE_W-1:0] got_value;
      got_index = tdata[INDEX_W-1:0];
      got_value = tdata[INDEX_W +: VALUE_W];
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: status %0d index %0d value %h",
                                  tuser, got_index, got_value));
      end else begin
        want = expected_q.pop_front();
        if (tuser !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", tuser, want.status));
        if (got_index !== want.stack_index)
          report_mismatch($sformatf("stack_index %0d, expected %0d", got_index,
                                    want.stack_index));
        if (got_value !== want.popped_value)
          report_mismatch($sformatf("popped_value %h, expected %h", got_value,
                                    want.popped_value));
      end
    endtask
  endclass

endpackage

/* tb/tb_top.sv */
// Top-level testbench for balanced_multi_stack_unit: clock, reset, stream drivers,
// result monitor and run control. Depends on bms_pkg and stack_bank_check_pkg.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bms_pkg::*;
  import stack_bank_check_pkg::*;

  localparam int unsigned IDLE_PCT     = 9;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned RANDOM_ITEMS = 1876;
  localparam int unsigned TAIL_CYCLES  = 8;
  localparam int unsigned CYCLE_LIMIT  = 100000;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic        in_tuser   = MODE_PUSH;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;

  stack_bank_scoreboard sb;

  // Random idling on both channels is switched off for one long stretch.
  bit          idle_on       = 1'b1;
  // Set by the stimulus to ask the result side for one long hold-off.
  bit          hold_request  = 1'b0;
  int unsigned cycle_count   = 0;

  balanced_multi_stack_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Offers one transaction and returns at the edge that accepts it or after the
  // idle gap drawn behind it. The valid stays high into the next call unless an
  // idle gap is drawn, so it is never lowered and raised within the same time step.
  task automatic send_item(input logic mode, input logic [15:0] value);
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    sb.note_request(mode, value);
    if (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Stops offering and waits until every expected result has been seen.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  // Draws a value that lands on the extremes now and then.
  function automatic logic [15:0] draw_value();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Result side: checks each accepted transaction, then picks the next ready.
  // The long hold-off is counted here so the sender keeps pushing meanwhile,
  // which fills both pipeline stages and forces in_tready low.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (idle_on && $urandom_range(99) < IDLE_PCT) begin
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    int unsigned sent;
    int unsigned burst;
    int unsigned burst_len;
    int unsigned push_pct;
    logic        mode;
    sb = new();
    sent  = 0;
    burst = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. A pop on an empty bank must report all empty at stack 0,
    // and its value field must be ignored.
    send_item(MODE_POP, 16'hFFFF);
    // Twenty pushes fill every stack, spreading round-robin from the lowest index.
    for (int i = 0; i < 20; i++) begin
      case (i)
        0:       send_item(MODE_PUSH, 16'hFFFF);
        1:       send_item(MODE_PUSH, 16'h0000);
        2:       send_item(MODE_PUSH, 16'hAAAA);
        3:       send_item(MODE_PUSH, 16'h5555);
        4:       send_item(MODE_PUSH, 16'h8000);
        5:       send_item(MODE_PUSH, 16'h0001);
        default: send_item(MODE_PUSH, draw_value());
      endcase
    end
    // With every stack full the push is dropped; then a pop and a refill.
    send_item(MODE_PUSH, 16'h1234);
    send_item(MODE_POP, 16'h0000);
    send_item(MODE_PUSH, 16'hFFFF);
    // The sender pauses here until all directed results are back.
    wait_drained();

    // Random part: bursts with a push bias that swings the bank between empty
    // and full, so both boundary cases recur with varied content.
    while (sent < RANDOM_ITEMS) begin
      burst_len = $urandom_range(20, 60);
      case ($urandom_range(3))
        0:       push_pct = 15;
        1:       push_pct = 85;
        2:       push_pct = 50;
        default: push_pct = $urandom_range(0, 100);
      endcase
      // A long stretch with no idling on either channel.
      idle_on = !(burst >= 10 && burst < 18);
      if (burst == 3 || burst == 25) hold_request = 1'b1;
      if (burst == 20) wait_drained();
      for (int k = 0; k < burst_len && sent < RANDOM_ITEMS; k++) begin
        mode = ($urandom_range(99) < push_pct) ? MODE_PUSH : MODE_POP;
        send_item(mode, draw_value());
        sent++;
      end
      burst++;
    end
    idle_on = 1'b1;

    wait_drained();
    // Any stray result would show within the pipeline latency.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

/* balanced_multi_stack_unit.f */
src/bms_pkg.sv
src/bms_occ.sv
src/bms_store.sv
src/balanced_multi_stack_unit.sv
tb/stack_bank_check_pkg.sv
tb/tb_top.sv
